@@ rtl/flm_pkg.sv @@
// Shared constants and types for the friend low-power-node destination matcher.
// No dependencies.
package flm_pkg;

    localparam int ADDR_W     = 16;
    localparam int KEY_W      = 12;
    localparam int COUNT_W    = 8;
    localparam int SLOT_W     = 3;
    localparam int CMD_W      = 2;
    localparam int RESULT_CAP = 8;
    localparam int CAP_W      = $clog2(RESULT_CAP);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_WR_CTX = 2'd1,
        CMD_WR_SUB = 2'd2
    } t_cmd;

endpackage

@@ rtl/flm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module flm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/friend_lpn_dest_matcher_core.sv @@
// Friend low-power-node destination matcher, top level.
// Depends on flm_pkg and flm_ram.
//
// Keeps NUM_CONTEXTS friendship contexts in flip-flops and their subscription
// lists in one RAM of NUM_CONTEXTS*SUBS_PER_CONTEXT entries. After reset the
// block zeroes every entry of the subscription RAM (64 with defaults) before
// it first raises o_in_ready. A write command passes through the S_ACK state
// before its acknowledge is registered at the output. A lookup walks the
// contexts in order; each context that is in use, established and on the
// requested subnet is searched entry by entry for a group or virtual
// destination, since the single read port of the subscription RAM returns
// one entry per cycle. A lookup also waits while the output side stalls.
// One transaction is in work at a time; results wait in an output register.
module friend_lpn_dest_matcher_core #(
    parameter int NUM_CONTEXTS     = 8,
    parameter int SUBS_PER_CONTEXT = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [flm_pkg::CMD_W-1:0]    i_cmd,
    input  logic [flm_pkg::SLOT_W-1:0]   i_ctx_slot,
    input  logic [flm_pkg::SLOT_W-1:0]   i_sub_slot,
    input  logic                         i_slot_valid,
    input  logic                         i_slot_established,
    input  logic [flm_pkg::KEY_W-1:0]    i_net_key_index,
    input  logic [flm_pkg::ADDR_W-1:0]   i_base_unicast,
    input  logic [flm_pkg::COUNT_W-1:0]  i_element_count,
    input  logic [flm_pkg::ADDR_W-1:0]   i_address,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_hit,
    output logic [flm_pkg::SLOT_W-1:0]   o_match_slot,
    output logic                         o_last
);

    localparam int DEPTH = NUM_CONTEXTS * SUBS_PER_CONTEXT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int SW    = (SUBS_PER_CONTEXT > 1) ? $clog2(SUBS_PER_CONTEXT) : 1;
    localparam int AWID  = flm_pkg::ADDR_W;
    localparam int SLW   = flm_pkg::SLOT_W;
    localparam int CPW   = flm_pkg::CAP_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CTX,
        S_SUB,
        S_FOUND,
        S_END,
        S_ACK
    } t_state;

    // context table
    logic                        r_ctx_in_use [NUM_CONTEXTS];
    logic                        r_ctx_estab  [NUM_CONTEXTS];
    logic [flm_pkg::KEY_W-1:0]   r_ctx_key    [NUM_CONTEXTS];
    logic [AWID-1:0]             r_ctx_base   [NUM_CONTEXTS];
    logic [flm_pkg::COUNT_W-1:0] r_ctx_count  [NUM_CONTEXTS];

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_c, n_c;
    logic [SW-1:0]             r_s, n_s;
    logic [AW-1:0]             r_clr, n_clr;
    logic                      r_pend_valid, n_pend_valid;
    logic [SLW-1:0]            r_pend_slot, n_pend_slot;
    logic [CPW-1:0]            r_count, n_count;
    logic [AWID-1:0]           r_dst, n_dst;
    logic [flm_pkg::KEY_W-1:0] r_key, n_key;
    logic                      r_uni, n_uni;
    logic                      r_grp, n_grp;
    logic                      r_out_valid, n_out_valid;
    logic                      r_out_hit, n_out_hit;
    logic [SLW-1:0]            r_out_slot, n_out_slot;
    logic                      r_out_last, n_out_last;

    logic            in_fire;
    logic            can_emit;
    logic            ctx_wr_ok;
    logic            sub_wr_ok;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AWID-1:0] ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [AWID-1:0] ram_rdata;
    logic [SW-1:0]   s_next;
    logic            s_at_end;
    logic            c_at_end;
    logic            ctx_qual;
    logic            uni_match;
    logic [AWID:0]   range_end;
    logic            grp_match;
    logic [SLW-1:0]  cur_slot;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign can_emit   = !r_out_valid || i_out_ready;

    assign ctx_wr_ok = (32'(i_ctx_slot) < NUM_CONTEXTS);
    assign sub_wr_ok = ctx_wr_ok && (32'(i_sub_slot) < SUBS_PER_CONTEXT);

    assign s_at_end = (r_s == SW'(SUBS_PER_CONTEXT - 1));
    assign s_next   = s_at_end ? r_s : r_s + SW'(1);
    assign c_at_end = (r_c == CW'(NUM_CONTEXTS - 1));
    assign cur_slot = SLW'(r_c);

    assign ram_we    = (r_state == S_CLEAR) ||
                       (in_fire && (i_cmd == flm_pkg::CMD_WR_SUB) && sub_wr_ok);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr :
                       AW'(32'(i_ctx_slot) * SUBS_PER_CONTEXT + 32'(i_sub_slot));
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : i_address;
    assign ram_raddr = (r_state == S_CTX) ? AW'(32'(r_c) * SUBS_PER_CONTEXT) :
                       AW'(32'(r_c) * SUBS_PER_CONTEXT + 32'(s_next));

    flm_ram #(
        .WIDTH (AWID),
        .DEPTH (DEPTH)
    ) u_sub_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared compare unit
    assign ctx_qual  = r_ctx_in_use[r_c] && r_ctx_estab[r_c] && (r_ctx_key[r_c] == r_key);
    assign range_end = {1'b0, r_ctx_base[r_c]} + (AWID + 1)'(r_ctx_count[r_c]);
    assign uni_match = (r_dst >= r_ctx_base[r_c]) && ({1'b0, r_dst} < range_end);
    assign grp_match = (ram_rdata != '0) && (ram_rdata == r_dst);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CONTEXTS; i++) begin
                r_ctx_in_use[i] <= 1'b0;
            end
        end else if (in_fire && (i_cmd == flm_pkg::CMD_WR_CTX) && ctx_wr_ok) begin
            r_ctx_in_use[CW'(i_ctx_slot)] <= i_slot_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && (i_cmd == flm_pkg::CMD_WR_CTX) && ctx_wr_ok) begin
            r_ctx_estab[CW'(i_ctx_slot)] <= i_slot_established;
            r_ctx_key[CW'(i_ctx_slot)]   <= i_net_key_index;
            r_ctx_base[CW'(i_ctx_slot)]  <= i_base_unicast;
            r_ctx_count[CW'(i_ctx_slot)] <= i_element_count;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_c          = r_c;
        n_s          = r_s;
        n_clr        = r_clr;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_count      = r_count;
        n_dst        = r_dst;
        n_key        = r_key;
        n_uni        = r_uni;
        n_grp        = r_grp;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_hit    = r_out_hit;
        n_out_slot   = r_out_slot;
        n_out_last   = r_out_last;

        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    if (i_cmd == flm_pkg::CMD_LOOKUP) begin
                        n_dst        = i_address;
                        n_key        = i_net_key_index;
                        n_uni        = (i_address != '0) && !i_address[AWID-1];
                        n_grp        = i_address[AWID-1];
                        n_c          = '0;
                        n_count      = '0;
                        n_pend_valid = 1'b0;
                        n_state      = S_CTX;
                    end else begin
                        n_state = S_ACK;
                    end
                end
            end
            S_CTX: begin
                n_s = '0;
                if (ctx_qual && r_uni && uni_match) begin
                    n_state = S_FOUND;
                end else if (ctx_qual && r_grp) begin
                    n_state = S_SUB;
                end else if (c_at_end) begin
                    n_state = S_END;
                end else begin
                    n_c = r_c + CW'(1);
                end
            end
            S_SUB: begin
                if (grp_match) begin
                    n_state = S_FOUND;
                end else if (s_at_end) begin
                    if (c_at_end) begin
                        n_state = S_END;
                    end else begin
                        n_c     = r_c + CW'(1);
                        n_state = S_CTX;
                    end
                end else begin
                    n_s = s_next;
                end
            end
            S_FOUND: begin
                if (r_pend_valid) begin
                    if (can_emit) begin
                        n_out_valid  = 1'b1;
                        n_out_hit    = 1'b1;
                        n_out_slot   = r_pend_slot;
                        n_out_last   = 1'b0;
                        n_pend_valid = 1'b0;
                        n_count      = r_count + CPW'(1);
                    end
                end else if (r_uni || (r_count == CPW'(flm_pkg::RESULT_CAP - 1))) begin
                    if (can_emit) begin
                        n_out_valid = 1'b1;
                        n_out_hit   = 1'b1;
                        n_out_slot  = cur_slot;
                        n_out_last  = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_pend_valid = 1'b1;
                    n_pend_slot  = cur_slot;
                    if (c_at_end) begin
                        n_state = S_END;
                    end else begin
                        n_c     = r_c + CW'(1);
                        n_state = S_CTX;
                    end
                end
            end
            S_END: begin
                if (can_emit) begin
                    n_out_valid  = 1'b1;
                    n_out_hit    = r_pend_valid;
                    n_out_slot   = r_pend_valid ? r_pend_slot : '0;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            S_ACK: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = 1'b0;
                    n_out_slot  = '0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_c          <= '0;
            r_s          <= '0;
            r_pend_valid <= 1'b0;
            r_count      <= '0;
            r_uni        <= 1'b0;
            r_grp        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_c          <= n_c;
            r_s          <= n_s;
            r_pend_valid <= n_pend_valid;
            r_count      <= n_count;
            r_uni        <= n_uni;
            r_grp        <= n_grp;
            r_out_valid  <= n_out_valid;
        end
        r_pend_slot <= n_pend_slot;
        r_dst       <= n_dst;
        r_key       <= n_key;
        r_out_hit   <= n_out_hit;
        r_out_slot  <= n_out_slot;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_match_slot = r_out_slot;
    assign o_last       = r_out_last;

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending match left over at end of lookup");

    a_miss_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_hit) |-> r_out_last)
        else $error("miss or acknowledge without last marker");

    a_write_acks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_cmd != flm_pkg::CMD_LOOKUP)) |=> (r_state == S_ACK))
        else $error("write transaction not acknowledged");

    a_pend_group_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_grp)
        else $error("pending match on non-group lookup");

endmodule

@@ tb/sv/flm_match_checker.sv @@
// Scoreboard for the friend low-power-node destination matcher: predicts the
// results of every accepted command and compares them with the block's output.
// Depends on flm_pkg.
module flm_match_checker #(
    parameter int NUM_CONTEXTS     = 8,
    parameter int SUBS_PER_CONTEXT = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [flm_pkg::CMD_W-1:0]    i_cmd,
    input  logic [flm_pkg::SLOT_W-1:0]   i_ctx_slot,
    input  logic [flm_pkg::SLOT_W-1:0]   i_sub_slot,
    input  logic                         i_slot_valid,
    input  logic                         i_slot_established,
    input  logic [flm_pkg::KEY_W-1:0]    i_net_key_index,
    input  logic [flm_pkg::ADDR_W-1:0]   i_base_unicast,
    input  logic [flm_pkg::COUNT_W-1:0]  i_element_count,
    input  logic [flm_pkg::ADDR_W-1:0]   i_address,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic                         i_hit,
    input  logic [flm_pkg::SLOT_W-1:0]   i_match_slot,
    input  logic                         i_last,
    output int                           o_mismatches,
    output int                           o_awaited,
    output int                           o_results,
    output int                           o_hits
);
    import flm_pkg::*;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } match_rec_t;

    match_rec_t          awaited_matches[$];
    match_rec_t          head;
    int                  mismatch_count = 0;
    int                  awaited_count  = 0;
    int                  result_count   = 0;
    int                  hit_count      = 0;

    logic                ctx_used [NUM_CONTEXTS];
    logic                ctx_est  [NUM_CONTEXTS];
    logic [KEY_W-1:0]    ctx_key  [NUM_CONTEXTS];
    logic [ADDR_W-1:0]   ctx_base [NUM_CONTEXTS];
    logic [COUNT_W-1:0]  ctx_cnt  [NUM_CONTEXTS];
    logic [ADDR_W-1:0]   sub_addr [NUM_CONTEXTS][SUBS_PER_CONTEXT];

    assign o_mismatches = mismatch_count;
    assign o_awaited    = awaited_count;
    assign o_results    = result_count;
    assign o_hits       = hit_count;

    task automatic report(input string what);
        if (mismatch_count < 50)
            $display("flm check @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic logic addressed_to(input int c, input logic [ADDR_W-1:0] dst);
        logic [ADDR_W:0] upper;
        if (dst == '0)
            return 1'b0;
        if (!dst[ADDR_W-1]) begin
            upper = {1'b0, ctx_base[c]} + ctx_cnt[c];
            return (dst >= ctx_base[c]) && ({1'b0, dst} < upper);
        end
        for (int s = 0; s < SUBS_PER_CONTEXT; s++) begin
            if (sub_addr[c][s] != '0 && sub_addr[c][s] == dst)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic apply_command();
        int         hit_slots[$];
        logic       unicast;
        match_rec_t rec;
        rec = '{hit: 1'b0, slot: '0, last: 1'b1};
        case (i_cmd)
            CMD_LOOKUP: begin
                unicast = (i_address != '0) && !i_address[ADDR_W-1];
                for (int c = 0; c < NUM_CONTEXTS && hit_slots.size() < RESULT_CAP; c++) begin
                    if (ctx_used[c] && ctx_est[c] && ctx_key[c] == i_net_key_index
                            && addressed_to(c, i_address)) begin
                        hit_slots.push_back(c);
                        if (unicast)
                            break;
                    end
                end
                foreach (hit_slots[i]) begin
                    rec.hit  = 1'b1;
                    rec.slot = SLOT_W'(hit_slots[i]);
                    rec.last = (i == hit_slots.size() - 1);
                    awaited_matches.push_back(rec);
                end
                if (hit_slots.size() == 0)
                    awaited_matches.push_back(rec);
            end
            CMD_WR_CTX: begin
                if (i_ctx_slot < NUM_CONTEXTS) begin
                    ctx_used[i_ctx_slot] = i_slot_valid;
                    ctx_est[i_ctx_slot]  = i_slot_established;
                    ctx_key[i_ctx_slot]  = i_net_key_index;
                    ctx_base[i_ctx_slot] = i_base_unicast;
                    ctx_cnt[i_ctx_slot]  = i_element_count;
                end
                awaited_matches.push_back(rec);
            end
            CMD_WR_SUB: begin
                if (i_ctx_slot < NUM_CONTEXTS && i_sub_slot < SUBS_PER_CONTEXT)
                    sub_addr[i_ctx_slot][i_sub_slot] = i_address;
                awaited_matches.push_back(rec);
            end
            default: begin
                awaited_matches.push_back(rec);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CONTEXTS; c++) begin
                ctx_used[c] = 1'b0;
                ctx_est[c]  = 1'b0;
                ctx_key[c]  = '0;
                ctx_base[c] = '0;
                ctx_cnt[c]  = '0;
                for (int s = 0; s < SUBS_PER_CONTEXT; s++)
                    sub_addr[c][s] = '0;
            end
            awaited_matches.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                apply_command();
            if (i_out_valid && i_out_ready) begin
                result_count++;
                if (i_hit)
                    hit_count++;
                if (awaited_matches.size() == 0) begin
                    report($sformatf("unexpected result hit=%0d slot=%0d last=%0d",
                                     i_hit, i_match_slot, i_last));
                end else begin
                    head = awaited_matches.pop_front();
                    if (i_hit !== head.hit)
                        report($sformatf("hit got %0d want %0d", i_hit, head.hit));
                    if (i_match_slot !== head.slot)
                        report($sformatf("match_slot got %0d want %0d", i_match_slot, head.slot));
                    if (i_last !== head.last)
                        report($sformatf("last got %0d want %0d", i_last, head.last));
                end
            end
        end
        awaited_count = awaited_matches.size();
    end

endmodule

@@ tb/sv/tb_friend_lpn_dest_matcher_core.sv @@
// Top of the destination matcher testbench: clock, reset, directed and random
// command traffic with random stalls on both channels, and the final verdict.
// Depends on flm_pkg, friend_lpn_dest_matcher_core and flm_match_checker.
module tb_friend_lpn_dest_matcher_core;
    import flm_pkg::*;

    localparam int                 CYCLE_LIMIT = 400000;
    localparam logic [CMD_W-1:0]   CMD_UNUSED  = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n            = 1'b0;
    logic                 i_in_valid         = 1'b0;
    logic                 o_in_ready;
    logic [CMD_W-1:0]     i_cmd              = '0;
    logic [SLOT_W-1:0]    i_ctx_slot         = '0;
    logic [SLOT_W-1:0]    i_sub_slot         = '0;
    logic                 i_slot_valid       = 1'b0;
    logic                 i_slot_established = 1'b0;
    logic [KEY_W-1:0]     i_net_key_index    = '0;
    logic [ADDR_W-1:0]    i_base_unicast     = '0;
    logic [COUNT_W-1:0]   i_element_count    = '0;
    logic [ADDR_W-1:0]    i_address          = '0;
    logic                 o_out_valid;
    logic                 i_out_ready        = 1'b0;
    logic                 o_hit;
    logic [SLOT_W-1:0]    o_match_slot;
    logic                 o_last;

    int                   mismatches, awaited, results, hits;
    int                   cycles      = 0;
    int                   n_lookups   = 0;
    int                   n_writes    = 0;
    int                   n_reserved  = 0;
    bit                   send_quiet  = 1'b0;
    bit                   drain_quiet = 1'b0;
    int                   stall;

    logic [ADDR_W-1:0]    base_of [8];
    logic [COUNT_W-1:0]   cnt_of  [8];
    logic [KEY_W-1:0]     key_pool   [4] = '{12'hABC, 12'h123, 12'hFFF, 12'h000};
    logic [ADDR_W-1:0]    group_pool [5] = '{16'hC000, 16'hFFFF, 16'h8000, 16'hBFFF, 16'hC0DE};

    friend_lpn_dest_matcher_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_cmd              (i_cmd),
        .i_ctx_slot         (i_ctx_slot),
        .i_sub_slot         (i_sub_slot),
        .i_slot_valid       (i_slot_valid),
        .i_slot_established (i_slot_established),
        .i_net_key_index    (i_net_key_index),
        .i_base_unicast     (i_base_unicast),
        .i_element_count    (i_element_count),
        .i_address          (i_address),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_hit              (o_hit),
        .o_match_slot       (o_match_slot),
        .o_last             (o_last)
    );

    flm_match_checker u_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_cmd              (i_cmd),
        .i_ctx_slot         (i_ctx_slot),
        .i_sub_slot         (i_sub_slot),
        .i_slot_valid       (i_slot_valid),
        .i_slot_established (i_slot_established),
        .i_net_key_index    (i_net_key_index),
        .i_base_unicast     (i_base_unicast),
        .i_element_count    (i_element_count),
        .i_address          (i_address),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_hit              (o_hit),
        .i_match_slot       (o_match_slot),
        .i_last             (o_last),
        .o_mismatches       (mismatches),
        .o_awaited          (awaited),
        .o_results          (results),
        .o_hits             (hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int pause_len(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        return ($urandom_range(0, 4) == 0) ? KEY_W'($urandom) : key_pool[$urandom_range(0, 3)];
    endfunction

    function automatic logic [ADDR_W-1:0] pick_group();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return group_pool[$urandom_range(0, 4)];
        if (r < 17)
            return '0;
        return ADDR_W'($urandom);
    endfunction

    task automatic send(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] cs,
                        input logic [SLOT_W-1:0] ss, input logic v, input logic e,
                        input logic [KEY_W-1:0] key, input logic [ADDR_W-1:0] base,
                        input logic [COUNT_W-1:0] cnt, input logic [ADDR_W-1:0] addr);
        int gap;
        if ($urandom_range(0, 11) == 0)
            send_quiet = !send_quiet;
        gap = pause_len(send_quiet);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd              = cmd;
        i_ctx_slot         = cs;
        i_sub_slot         = ss;
        i_slot_valid       = v;
        i_slot_established = e;
        i_net_key_index    = key;
        i_base_unicast     = base;
        i_element_count    = cnt;
        i_address          = addr;
        i_in_valid         = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        case (cmd)
            CMD_LOOKUP: n_lookups++;
            CMD_WR_CTX, CMD_WR_SUB: n_writes++;
            default: n_reserved++;
        endcase
    endtask

    task automatic wr_ctx(input logic [SLOT_W-1:0] cs, input logic v, input logic e,
                          input logic [KEY_W-1:0] key, input logic [ADDR_W-1:0] base,
                          input logic [COUNT_W-1:0] cnt);
        base_of[cs] = base;
        cnt_of[cs]  = cnt;
        send(CMD_WR_CTX, cs, SLOT_W'($urandom), v, e, key, base, cnt, ADDR_W'($urandom));
    endtask

    task automatic wr_sub(input logic [SLOT_W-1:0] cs, input logic [SLOT_W-1:0] ss,
                          input logic [ADDR_W-1:0] addr);
        send(CMD_WR_SUB, cs, ss, 1'($urandom), 1'($urandom), KEY_W'($urandom),
             ADDR_W'($urandom), COUNT_W'($urandom), addr);
    endtask

    task automatic lookup(input logic [KEY_W-1:0] key, input logic [ADDR_W-1:0] dst);
        send(CMD_LOOKUP, SLOT_W'($urandom), SLOT_W'($urandom), 1'($urandom), 1'($urandom),
             key, ADDR_W'($urandom), COUNT_W'($urandom), dst);
    endtask

    task automatic random_item();
        int                 r;
        int                 c;
        logic [ADDR_W-1:0]  base;
        logic [COUNT_W-1:0] cnt;
        logic [ADDR_W-1:0]  dst;
        r = $urandom_range(0, 99);
        if (r < 14) begin
            case ($urandom_range(0, 3))
                0:       base = ADDR_W'($urandom);
                1:       base = ADDR_W'($urandom_range(0, 32));
                default: base = ADDR_W'($urandom_range(1, 16'h7F00));
            endcase
            cnt = ($urandom_range(0, 9) < 7) ? COUNT_W'($urandom_range(0, 8))
                                            : COUNT_W'($urandom);
            wr_ctx(SLOT_W'($urandom), $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                   pick_key(), base, cnt);
        end else if (r < 32) begin
            wr_sub(SLOT_W'($urandom), SLOT_W'($urandom), pick_group());
        end else if (r < 36) begin
            send(CMD_UNUSED, SLOT_W'($urandom), SLOT_W'($urandom), 1'($urandom), 1'($urandom),
                 KEY_W'($urandom), ADDR_W'($urandom), COUNT_W'($urandom), ADDR_W'($urandom));
        end else begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                c   = $urandom_range(0, 7);
                dst = base_of[c] - 1'b1 + ADDR_W'($urandom_range(0, cnt_of[c] + 2));
            end else if (r < 75) begin
                dst = group_pool[$urandom_range(0, 4)];
            end else if (r < 85) begin
                dst = '0;
            end else begin
                dst = ADDR_W'($urandom);
            end
            lookup(pick_key(), dst);
        end
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 15) == 0)
                drain_quiet = !drain_quiet;
            stall = pause_len(drain_quiet);
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        foreach (base_of[c]) begin
            base_of[c] = '0;
            cnt_of[c]  = '0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        lookup(12'h000, 16'h0000);
        send(CMD_UNUSED, 3'd7, 3'd7, 1'b1, 1'b1, 12'hFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
        wr_ctx(3'd0, 1'b1, 1'b1, 12'hABC, 16'h0001, 8'd2);
        wr_ctx(3'd1, 1'b1, 1'b1, 12'hABC, 16'h0002, 8'hFF);
        wr_ctx(3'd2, 1'b0, 1'b1, 12'hABC, 16'h0000, 8'hFF);
        wr_ctx(3'd3, 1'b1, 1'b0, 12'hABC, 16'h0000, 8'hFF);
        wr_ctx(3'd7, 1'b1, 1'b1, 12'hFFF, 16'h7F80, 8'hFF);
        wr_ctx(3'd6, 1'b1, 1'b1, 12'hABC, 16'hFFFF, 8'hFF);
        lookup(12'hABC, 16'h0002);
        lookup(12'hABC, 16'h0003);
        lookup(12'h000, 16'h0001);
        lookup(12'hFFF, 16'h7FFF);
        lookup(12'hABC, 16'h0000);
        wr_sub(3'd0, 3'd0, 16'hC000);
        wr_sub(3'd1, 3'd7, 16'hC000);
        wr_sub(3'd6, 3'd3, 16'h8000);
        wr_sub(3'd3, 3'd0, 16'hC000);
        lookup(12'hABC, 16'hC000);
        lookup(12'hABC, 16'h8000);
        lookup(12'hABC, 16'hBFFF);
        wr_sub(3'd0, 3'd0, 16'h0000);
        lookup(12'hABC, 16'hC000);

        for (int c = 0; c < 8; c++) begin
            wr_ctx(SLOT_W'(c), 1'b1, 1'b1, 12'h123, ADDR_W'(16'h0100 + 4 * c), 8'd4);
            wr_sub(SLOT_W'(c), SLOT_W'(7 - c), 16'hFFFF);
        end
        lookup(12'h123, 16'hFFFF);
        lookup(12'h123, 16'h0105);

        repeat (130) random_item();

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (awaited != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);

        $display("summary: %0d lookups, %0d table writes, %0d reserved commands",
                 n_lookups, n_writes, n_reserved);
        $display("summary: %0d results compared, %0d of them context hits", results, hits);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/flm_pkg.sv
rtl/flm_ram.sv
rtl/friend_lpn_dest_matcher_core.sv
tb/sv/flm_match_checker.sv
tb/sv/tb_friend_lpn_dest_matcher_core.sv
